>>> rtl/i2cms_pkg.sv
package i2cms_pkg;

	// status codes reported on the last phase of an item
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
	localparam logic [1:0] STATUS_DATA_NACK = 2'd2;

	// source of the SDA level for a phase
	typedef logic [1:0] sda_sel_t;
	localparam sda_sel_t SDA_ONE  = 2'd0;
	localparam sda_sel_t SDA_ZERO = 2'd1;
	localparam sda_sel_t SDA_BIT  = 2'd2;
	localparam sda_sel_t SDA_ACK  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     emit;
		logic     scl;
		sda_sel_t sda_sel;
		logic     run_end;
		logic     skip;
		logic     shift;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic first;
		logic busy;
		logic stop_req;
		logic bit_last;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/i2cms_in_if.sv
interface i2cms_in_if;
	logic       valid;
	logic       ready;
	logic       first;
	logic       final_byte;
	logic       read_mode;
	logic [7:0] data_byte;
	logic       slave_ack;
	logic [7:0] slave_bits;

	modport source(output valid, output first, output final_byte, output read_mode,
		output data_byte, output slave_ack, output slave_bits, input ready);
	modport sink(input valid, input first, input final_byte, input read_mode,
		input data_byte, input slave_ack, input slave_bits, output ready);
endinterface

>>> rtl/i2cms_out_if.sv
interface i2cms_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       run_end;
	logic [7:0] read_data;
	logic       ack_seen;
	logic [1:0] status;
	logic       skipped;

	modport source(output valid, output scl_level, output sda_level, output run_end,
		output read_data, output ack_seen, output status, output skipped, input ready);
	modport sink(input valid, input scl_level, input sda_level, input run_end,
		input read_data, input ack_seen, input status, input skipped, output ready);
endinterface

>>> rtl/i2cms_datapath.sv
module i2cms_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              first,
	input  logic              final_byte,
	input  logic              read_mode,
	input  logic [7:0]        data_byte,
	input  logic              slave_ack,
	input  logic [7:0]        slave_bits,
	input  i2cms_pkg::cmd_t   cmd,
	output i2cms_pkg::stat_t  st,
	i2cms_out_if.source       result
);
	import i2cms_pkg::*;

	logic       first_q;
	logic       fin_q;
	logic       sack_q;
	logic       recv_q;
	logic [7:0] rx_q;
	logic [7:0] tx_q;
	logic [2:0] cnt_q;
	logic       busy_q;
	logic       reading_q;
	logic [1:0] err_q;
	logic       out_valid_q;
	logic       scl_q;
	logic       sda_q;
	logic       run_end_q;
	logic [7:0] read_data_q;
	logic       ack_seen_q;
	logic [1:0] status_q;
	logic       skipped_q;

	logic       nack;
	logic       stop_req;
	logic       sda_d;
	logic       done;
	logic [1:0] status_d;

	assign nack     = !recv_q && sack_q;
	assign stop_req = nack || fin_q;
	assign done     = cmd.run_end && !cmd.skip;

	always_comb begin
		case (cmd.sda_sel)
			SDA_ONE:  sda_d = 1'b1;
			SDA_ZERO: sda_d = 1'b0;
			SDA_BIT:  sda_d = tx_q[7];
			SDA_ACK:  sda_d = recv_q ? fin_q : 1'b1;
			default:  sda_d = 1'b1;
		endcase
	end

	always_comb begin
		if (!cmd.run_end) begin
			status_d = STATUS_OK;
		end else if (cmd.skip) begin
			status_d = err_q;
		end else if (nack) begin
			status_d = first_q ? STATUS_ADDR_NACK : STATUS_DATA_NACK;
		end else begin
			status_d = STATUS_OK;
		end
	end

	// item registers and bit shifter
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			first_q <= first;
			fin_q   <= final_byte;
			sack_q  <= slave_ack;
			rx_q    <= slave_bits;
			cnt_q   <= 3'd7;
			if (first) begin
				recv_q <= 1'b0;
				tx_q   <= read_mode ? (data_byte | 8'h01) : data_byte;
			end else begin
				// read data bits: master keeps SDA released
				recv_q <= reading_q;
				tx_q   <= reading_q ? 8'hFF : data_byte;
			end
		end else if (cmd.shift) begin
			tx_q  <= {tx_q[6:0], 1'b1};
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			reading_q <= 1'b0;
			err_q     <= STATUS_OK;
		end else if (cmd.load && first) begin
			busy_q    <= 1'b1;
			reading_q <= read_mode;
			err_q     <= STATUS_OK;
		end else if (cmd.emit && done) begin
			if (stop_req) begin
				busy_q <= 1'b0;
			end
			if (nack) begin
				err_q <= first_q ? STATUS_ADDR_NACK : STATUS_DATA_NACK;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			scl_q       <= cmd.scl;
			sda_q       <= sda_d;
			run_end_q   <= cmd.run_end;
			read_data_q <= (done && recv_q) ? rx_q : 8'h00;
			ack_seen_q  <= (done && !recv_q) ? sack_q : 1'b0;
			status_q    <= status_d;
			skipped_q   <= cmd.skip;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.scl_level = scl_q;
	assign result.sda_level = sda_q;
	assign result.run_end   = run_end_q;
	assign result.read_data = read_data_q;
	assign result.ack_seen  = ack_seen_q;
	assign result.status    = status_q;
	assign result.skipped   = skipped_q;

	assign st.first    = first_q;
	assign st.busy     = busy_q;
	assign st.stop_req = stop_req;
	assign st.bit_last = (cnt_q == 3'd0);
	assign st.out_free = !out_valid_q || result.ready;

endmodule

>>> rtl/i2cms_controller.sv
module i2cms_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  i2cms_pkg::stat_t  st,
	output i2cms_pkg::cmd_t   cmd
);
	import i2cms_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_START0 = 4'd2;
	localparam logic [3:0] S_START1 = 4'd3;
	localparam logic [3:0] S_START2 = 4'd4;
	localparam logic [3:0] S_BIT_LO = 4'd5;
	localparam logic [3:0] S_BIT_HI = 4'd6;
	localparam logic [3:0] S_ACK0   = 4'd7;
	localparam logic [3:0] S_ACK1   = 4'd8;
	localparam logic [3:0] S_ACK2   = 4'd9;
	localparam logic [3:0] S_STOP0  = 4'd10;
	localparam logic [3:0] S_STOP1  = 4'd11;
	localparam logic [3:0] S_STOP2  = 4'd12;
	localparam logic [3:0] S_SKIP   = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.first) begin
					state_d = S_START0;
				end else if (st.busy) begin
					state_d = S_BIT_LO;
				end else begin
					state_d = S_SKIP;
				end
			end
			default: begin
				// every other state puts out one line phase; hold while the output is full
				if (st.out_free) begin
					cmd.emit = 1'b1;
					case (state_q)
						S_START0: begin
							cmd.scl = 1'b1; cmd.sda_sel = SDA_ONE;  state_d = S_START1;
						end
						S_START1: begin
							cmd.scl = 1'b1; cmd.sda_sel = SDA_ZERO; state_d = S_START2;
						end
						S_START2: begin
							cmd.scl = 1'b0; cmd.sda_sel = SDA_ZERO; state_d = S_BIT_LO;
						end
						S_BIT_LO: begin
							cmd.scl = 1'b0; cmd.sda_sel = SDA_BIT;  state_d = S_BIT_HI;
						end
						S_BIT_HI: begin
							cmd.scl     = 1'b1;
							cmd.sda_sel = SDA_BIT;
							if (st.bit_last) begin
								state_d = S_ACK0;
							end else begin
								cmd.shift = 1'b1;
								state_d   = S_BIT_LO;
							end
						end
						S_ACK0: begin
							cmd.scl = 1'b0; cmd.sda_sel = SDA_ACK;  state_d = S_ACK1;
						end
						S_ACK1: begin
							cmd.scl = 1'b1; cmd.sda_sel = SDA_ACK;  state_d = S_ACK2;
						end
						S_ACK2: begin
							cmd.scl     = 1'b0;
							cmd.sda_sel = SDA_ONE;
							cmd.run_end = !st.stop_req;
							state_d     = st.stop_req ? S_STOP0 : S_IDLE;
						end
						S_STOP0: begin
							cmd.scl = 1'b0; cmd.sda_sel = SDA_ZERO; state_d = S_STOP1;
						end
						S_STOP1: begin
							cmd.scl = 1'b1; cmd.sda_sel = SDA_ZERO; state_d = S_STOP2;
						end
						S_STOP2: begin
							cmd.scl     = 1'b1;
							cmd.sda_sel = SDA_ONE;
							cmd.run_end = 1'b1;
							state_d     = S_IDLE;
						end
						S_SKIP: begin
							cmd.scl     = 1'b1;
							cmd.sda_sel = SDA_ONE;
							cmd.run_end = 1'b1;
							cmd.skip    = 1'b1;
							state_d     = S_IDLE;
						end
						default: begin
							cmd.emit = 1'b0;
							state_d  = S_IDLE;
						end
					endcase
				end
			end
		endcase
	end

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DECODE)
		else $error("accepted transfer not followed by decode");

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("phase emitted into a full output register");

	a_end_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.run_end |=> state_q == S_IDLE)
		else $error("item ended without returning to idle");

	a_shift_in_bits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> state_q == S_BIT_HI && !st.bit_last)
		else $error("shift outside a bit phase");

endmodule

>>> rtl/i2c_master_byte_sequencer.sv
// Byte sequencer for a bit-level I2C master. Each input transfer carries one transaction byte;
// an item with first set sends a start, the address byte and the ack clock, later items send
// or receive one data byte, and a stop follows the final byte or a slave NACK. Every output
// transfer is one SCL/SDA line phase. An item is accepted in idle, decoded, and then put out
// as line phases: up to 25 phases for an address with stop, 19 for a plain data byte, and
// one for a skipped item. The phase state machine emits one phase per cycle, unless the
// output is stalled, into a single output register; the next item is taken only in idle.
module i2c_master_byte_sequencer (
	input  logic   clk,
	input  logic   arst_n,
	i2cms_in_if.sink    item,
	i2cms_out_if.source result
);
	import i2cms_pkg::*;

	cmd_t  cmd;
	stat_t st;
	logic  in_ready;

	assign item.ready = in_ready;

	i2cms_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	i2cms_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.first      (item.first),
		.final_byte (item.final_byte),
		.read_mode  (item.read_mode),
		.data_byte  (item.data_byte),
		.slave_ack  (item.slave_ack),
		.slave_bits (item.slave_bits),
		.cmd        (cmd),
		.st         (st),
		.result     (result)
	);

endmodule

>>> tb/i2c_master_byte_sequencer_tb.sv
`timescale 1ns / 100ps

module i2c_master_byte_sequencer_tb;
	import i2cms_pkg::*;

	typedef struct packed {
		logic       first;
		logic       final_byte;
		logic       read_mode;
		logic [7:0] data_byte;
		logic       slave_ack;
		logic [7:0] slave_bits;
	} byte_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       run_end;
		logic [7:0] read_data;
		logic       ack_seen;
		logic [1:0] status;
		logic       skipped;
	} line_phase_t;

	localparam int RANDOM_ITEMS = 330;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 40;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	i2cms_in_if  item_if();
	i2cms_out_if result_if();

	i2c_master_byte_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	always #5ns clk = ~clk;

	// predicted bus state
	logic        bus_open;
	logic        read_dir;
	logic [1:0]  last_error;

	line_phase_t phases_due[$];
	int          error_count = 0;
	int          items_sent  = 0;
	int          idle_cycles = 0;
	bit          no_idle     = 1'b0;

	function automatic byte_item_t make_item(input logic first, input logic final_byte,
		input logic read_mode, input logic [7:0] data_byte, input logic slave_ack,
		input logic [7:0] slave_bits);
		byte_item_t it;
		it.first      = first;
		it.final_byte = final_byte;
		it.read_mode  = read_mode;
		it.data_byte  = data_byte;
		it.slave_ack  = slave_ack;
		it.slave_bits = slave_bits;
		return it;
	endfunction

	task automatic push_phase(input logic scl, input logic sda);
		line_phase_t p;
		p = '0;
		p.scl_level = scl;
		p.sda_level = sda;
		phases_due.push_back(p);
	endtask

	// tag the last phase of the item with its summary fields
	task automatic close_item(input logic [7:0] rd, input logic ack, input logic [1:0] st,
		input logic skip);
		int last;
		last = phases_due.size() - 1;
		phases_due[last].run_end   = 1'b1;
		phases_due[last].read_data = rd;
		phases_due[last].ack_seen  = ack;
		phases_due[last].status    = st;
		phases_due[last].skipped   = skip;
	endtask

	task automatic push_stop();
		push_phase(1'b0, 1'b0);
		push_phase(1'b1, 1'b0);
		push_phase(1'b1, 1'b1);
	endtask

	task automatic push_sent_byte(input logic [7:0] b);
		for (int i = 7; i >= 0; i--) begin
			push_phase(1'b0, b[i]);
			push_phase(1'b1, b[i]);
		end
		push_phase(1'b0, 1'b1);
		push_phase(1'b1, 1'b1);
		push_phase(1'b0, 1'b1);
	endtask

	task automatic predict_phases(input byte_item_t it);
		if (it.first) begin
			bus_open   = 1'b1;
			read_dir   = it.read_mode;
			last_error = STATUS_OK;
			push_phase(1'b1, 1'b1);
			push_phase(1'b1, 1'b0);
			push_phase(1'b0, 1'b0);
			push_sent_byte(read_dir ? (it.data_byte | 8'h01) : it.data_byte);
			if (it.slave_ack) begin
				push_stop();
				bus_open   = 1'b0;
				last_error = STATUS_ADDR_NACK;
				close_item(8'h00, 1'b1, STATUS_ADDR_NACK, 1'b0);
			end else begin
				if (it.final_byte) begin
					push_stop();
					bus_open = 1'b0;
				end
				close_item(8'h00, 1'b0, STATUS_OK, 1'b0);
			end
		end else if (!bus_open) begin
			push_phase(1'b1, 1'b1);
			close_item(8'h00, 1'b0, last_error, 1'b1);
		end else if (read_dir) begin
			for (int i = 0; i < 8; i++) begin
				push_phase(1'b0, 1'b1);
				push_phase(1'b1, 1'b1);
			end
			// master answers NACK on the final byte
			push_phase(1'b0, it.final_byte);
			push_phase(1'b1, it.final_byte);
			push_phase(1'b0, 1'b1);
			if (it.final_byte) begin
				push_stop();
				bus_open = 1'b0;
			end
			close_item(it.slave_bits, 1'b0, STATUS_OK, 1'b0);
		end else begin
			push_sent_byte(it.data_byte);
			if (it.slave_ack) begin
				push_stop();
				bus_open   = 1'b0;
				last_error = STATUS_DATA_NACK;
				close_item(8'h00, 1'b1, STATUS_DATA_NACK, 1'b0);
			end else begin
				if (it.final_byte) begin
					push_stop();
					bus_open = 1'b0;
				end
				close_item(8'h00, 1'b0, STATUS_OK, 1'b0);
			end
		end
	endtask

	// hold valid high across back-to-back transfers; drop it only before a gap
	task automatic send_item(input byte_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid      <= 1'b1;
		item_if.first      <= it.first;
		item_if.final_byte <= it.final_byte;
		item_if.read_mode  <= it.read_mode;
		item_if.data_byte  <= it.data_byte;
		item_if.slave_ack  <= it.slave_ack;
		item_if.slave_bits <= it.slave_bits;
		do @(posedge clk); while (!item_if.ready);
		predict_phases(it);
		items_sent++;
	endtask

	task automatic check_field(input string name, input int exp, input int act);
		if (exp != act) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp, act);
			error_count++;
		end
	endtask

	initial begin : result_sink
		int          stall;
		line_phase_t exp;
		result_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			if (phases_due.size() == 0) begin
				$error("unexpected line phase: scl %0b sda %0b", result_if.scl_level,
					result_if.sda_level);
				error_count++;
			end else begin
				exp = phases_due.pop_front();
				check_field("scl_level", int'(exp.scl_level), int'(result_if.scl_level));
				check_field("sda_level", int'(exp.sda_level), int'(result_if.sda_level));
				check_field("run_end", int'(exp.run_end), int'(result_if.run_end));
				check_field("read_data", int'(exp.read_data), int'(result_if.read_data));
				check_field("ack_seen", int'(exp.ack_seen), int'(result_if.ack_seen));
				check_field("status", int'(exp.status), int'(result_if.status));
				check_field("skipped", int'(exp.skipped), int'(result_if.skipped));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[i2c_master_byte_sequencer] ERROR");
				$finish;
			end
		end
	end

	task automatic test_skipped_without_start();
		send_item(make_item(1'b0, 1'b0, 1'b0, 8'hA5, 1'b0, 8'h00));
		send_item(make_item(1'b0, 1'b1, 1'b1, 8'h5A, 1'b1, 8'hFF));
	endtask

	task automatic test_write_transfers();
		send_item(make_item(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 8'hFF));
		send_item(make_item(1'b0, 1'b0, 1'b0, 8'hFF, 1'b0, 8'h00));
		send_item(make_item(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 8'hFF));
	endtask

	task automatic test_nack_abort();
		// address NACK, then later bytes are skipped with the stored status
		send_item(make_item(1'b1, 1'b0, 1'b0, 8'hFF, 1'b1, 8'h00));
		send_item(make_item(1'b0, 1'b0, 1'b0, 8'h11, 1'b0, 8'h00));
		send_item(make_item(1'b0, 1'b1, 1'b0, 8'h22, 1'b0, 8'h00));
		// data NACK
		send_item(make_item(1'b1, 1'b0, 1'b0, 8'h42, 1'b0, 8'h00));
		send_item(make_item(1'b0, 1'b0, 1'b0, 8'hAA, 1'b1, 8'h00));
		send_item(make_item(1'b0, 1'b1, 1'b0, 8'h55, 1'b0, 8'h00));
	endtask

	task automatic test_read_transfers();
		send_item(make_item(1'b1, 1'b0, 1'b1, 8'hA4, 1'b0, 8'h00));
		// direction and slave ack on a read data byte must be ignored
		send_item(make_item(1'b0, 1'b0, 1'b0, 8'h33, 1'b1, 8'hFF));
		send_item(make_item(1'b0, 1'b1, 1'b1, 8'hCC, 1'b0, 8'h00));
		// read with no data bytes: address then stop only
		send_item(make_item(1'b1, 1'b1, 1'b1, 8'hA5, 1'b0, 8'h3C));
		send_item(make_item(1'b1, 1'b0, 1'b1, 8'hFE, 1'b1, 8'h00));
		send_item(make_item(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00));
	endtask

	task automatic test_repeated_start();
		send_item(make_item(1'b1, 1'b0, 1'b0, 8'h3C, 1'b0, 8'h00));
		send_item(make_item(1'b0, 1'b0, 1'b0, 8'h81, 1'b0, 8'h00));
		send_item(make_item(1'b1, 1'b0, 1'b1, 8'h3D, 1'b0, 8'h00));
		send_item(make_item(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 8'h7E));
		send_item(make_item(1'b1, 1'b1, 1'b0, 8'h50, 1'b0, 8'h00));
	endtask

	task automatic test_random_transactions();
		int   nbytes;
		logic rd;
		logic fin;
		while (items_sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0) begin
				send_item(make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
			end else begin
				nbytes = $urandom_range(0, 5);
				rd     = 1'($urandom_range(0, 1));
				send_item(make_item(1'b1, nbytes == 0, rd, 8'($urandom_range(0, 255)),
					$urandom_range(0, 9) == 0, 8'($urandom_range(0, 255))));
				for (int k = 0; k < nbytes; k++) begin
					// leave some transactions open so that a repeated start follows
					fin = (k == nbytes - 1) && ($urandom_range(0, 7) != 0);
					send_item(make_item(1'b0, fin, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
						8'($urandom_range(0, 255))));
				end
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		item_if.valid      <= 1'b0;
		item_if.first      <= 1'b0;
		item_if.final_byte <= 1'b0;
		item_if.read_mode  <= 1'b0;
		item_if.data_byte  <= 8'h00;
		item_if.slave_ack  <= 1'b0;
		item_if.slave_bits <= 8'h00;
		bus_open   = 1'b0;
		read_dir   = 1'b0;
		last_error = STATUS_OK;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_skipped_without_start();
		test_write_transfers();
		test_nack_abort();
		test_read_transfers();
		test_repeated_start();
		test_random_transactions();

		item_if.valid <= 1'b0;
		while (phases_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (phases_due.size() != 0) begin
			$error("%0d line phases never arrived", phases_due.size());
			error_count++;
		end
		if (error_count == 0)
			$display("[i2c_master_byte_sequencer] OK");
		else
			$display("[i2c_master_byte_sequencer] ERROR");
		$finish;
	end

endmodule
